[rtl/core/tsc_pkg.sv]
package tsc_pkg;

  // Series length: terms after the leading x (sine) and after the leading 1 (cosine)
  localparam int TERMS_DEF = 3;

  localparam int ANGLE_W    = 16;
  localparam int OUT_W      = 16;
  localparam int MAG_W      = 16;
  localparam int ANGLE_FRAC = 13;
  localparam int POW_FRAC   = 24;
  localparam int OUT_FRAC   = 12;

  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32768;
  localparam int COS_ONE = 4096;

  function automatic longint unsigned fact(input int n);
    longint unsigned f;
    f = 64'd1;
    for (int i = 2; i <= n; i++) begin
      f = f * longint'(unsigned'(i));
    end
    return f;
  endfunction

endpackage

[rtl/core/taylor_sine_cosine_core.sv]
// Throughput: one angle per cycle while the output buffer has room; each power of x
// passes a seven-stage step (split multiply, round, factorial divide by reciprocal,
// correct and accumulate). A two-entry output buffer keeps the pipeline moving
// while a result waits.
// Reset (rst_n low, synchronous) clears all valid bits and the buffer; no clearing pass.
module taylor_sine_cosine_core #(
  parameter int TERMS = tsc_pkg::TERMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tsc_pkg::ANGLE_W-1:0]  in_angle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tsc_pkg::OUT_W-1:0]    out_sine_value,
  output logic signed [tsc_pkg::OUT_W-1:0]    out_cosine_value
);

  localparam int EMAX  = 2 * TERMS + 1;
  localparam int NSTEP = EMAX - 1;
  localparam int PW    = 2 * EMAX + tsc_pkg::POW_FRAC + 1;
  localparam int QW    = PW - tsc_pkg::OUT_FRAC;
  localparam int SW    = QW + 4;
  localparam int MW    = tsc_pkg::MAG_W;
  localparam logic signed [SW-1:0] SAT_HI = SW'(tsc_pkg::OUT_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(tsc_pkg::OUT_MIN);

  logic                 en;
  logic                 room;

  logic                 v_s   [0:NSTEP];
  logic [MW-1:0]        mag_s [0:NSTEP];
  logic                 neg_s [0:NSTEP];
  logic [PW-1:0]        pow_s [0:NSTEP];
  logic signed [SW-1:0] sa_s  [0:NSTEP];
  logic signed [SW-1:0] ca_s  [0:NSTEP];

  logic                 v0_r;
  logic [MW-1:0]        mag0_r;
  logic                 neg0_r;
  logic signed [SW-1:0] sa0_r;

  logic                 neg_nxt;
  logic [MW-1:0]        mag_nxt;
  logic [MW:0]          half_sum;
  logic signed [SW-1:0] first_s;
  logic signed [SW-1:0] sa0_nxt;

  logic signed [tsc_pkg::OUT_W-1:0] sin_sat, cos_sat;
  logic                             push;

  assign en       = room;
  assign in_ready = en;

  // magnitude of the angle; full-scale negative maps to 0x8000
  assign neg_nxt  = in_angle[tsc_pkg::ANGLE_W-1];
  assign mag_nxt  = neg_nxt ? (~in_angle + MW'(1)) : in_angle;
  assign half_sum = {1'b0, mag_nxt} + (MW+1)'(1);
  assign first_s  = $signed(SW'(half_sum[MW:1]));
  assign sa0_nxt  = neg_nxt ? -first_s : first_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag0_r <= mag_nxt;
      neg0_r <= neg_nxt;
      sa0_r  <= sa0_nxt;
    end
  end

  assign v_s[0]   = v0_r;
  assign mag_s[0] = mag0_r;
  assign neg_s[0] = neg0_r;
  assign pow_s[0] = PW'(mag0_r) << (tsc_pkg::POW_FRAC - tsc_pkg::ANGLE_FRAC);
  assign sa_s[0]  = sa0_r;
  assign ca_s[0]  = SW'(tsc_pkg::COS_ONE);

  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    tsc_pow_step #(
      .E  (k + 1),
      .PW (PW),
      .QW (QW),
      .SW (SW)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_v    (v_s[k-1]),
      .in_mag  (mag_s[k-1]),
      .in_neg  (neg_s[k-1]),
      .in_pow  (pow_s[k-1]),
      .in_sa   (sa_s[k-1]),
      .in_ca   (ca_s[k-1]),
      .out_v   (v_s[k]),
      .out_mag (mag_s[k]),
      .out_neg (neg_s[k]),
      .out_pow (pow_s[k]),
      .out_sa  (sa_s[k]),
      .out_ca  (ca_s[k])
    );
  end

  // clamp the wide sums to the output range
  always_comb begin
    if (sa_s[NSTEP] > SAT_HI) begin
      sin_sat = tsc_pkg::OUT_W'(tsc_pkg::OUT_MAX);
    end else if (sa_s[NSTEP] < SAT_LO) begin
      sin_sat = tsc_pkg::OUT_W'(tsc_pkg::OUT_MIN);
    end else begin
      sin_sat = sa_s[NSTEP][tsc_pkg::OUT_W-1:0];
    end
    if (ca_s[NSTEP] > SAT_HI) begin
      cos_sat = tsc_pkg::OUT_W'(tsc_pkg::OUT_MAX);
    end else if (ca_s[NSTEP] < SAT_LO) begin
      cos_sat = tsc_pkg::OUT_W'(tsc_pkg::OUT_MIN);
    end else begin
      cos_sat = ca_s[NSTEP][tsc_pkg::OUT_W-1:0];
    end
  end

  assign push = v_s[NSTEP] && en;

  tsc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_sin  (sin_sat),
    .push_cos  (cos_sat),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_sin   (out_sine_value),
    .out_cos   (out_cosine_value)
  );

endmodule

[rtl/core/tsc_pow_step.sv]
module tsc_pow_step #(
  parameter int E  = 2,
  parameter int PW = 39,
  parameter int QW = 27,
  parameter int SW = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  logic [tsc_pkg::MAG_W-1:0]     in_mag,
  input  logic                          in_neg,
  input  logic [PW-1:0]                 in_pow,
  input  logic signed [SW-1:0]          in_sa,
  input  logic signed [SW-1:0]          in_ca,
  output logic                          out_v,
  output logic [tsc_pkg::MAG_W-1:0]     out_mag,
  output logic                          out_neg,
  output logic [PW-1:0]                 out_pow,
  output logic signed [SW-1:0]          out_sa,
  output logic signed [SW-1:0]          out_ca
);

  localparam int NST    = 7;
  localparam int PL     = PW / 2;
  localparam int PH     = PW - PL;
  localparam int PROD_W = PW + tsc_pkg::MAG_W + 1;
  localparam longint unsigned FACT  = tsc_pkg::fact(E);
  localparam longint unsigned HALFD = FACT << (tsc_pkg::OUT_FRAC - 1);
  localparam longint unsigned RECIP = (64'd1 << QW) / FACT;
  localparam longint unsigned RND_POW = 64'd1 << (tsc_pkg::ANGLE_FRAC - 1);
  localparam bit ODD      = (E % 2) == 1;
  localparam bit BASE_NEG = (((E - 2) / 2) % 2) == 0;

  logic                          v_r   [1:NST];
  logic [tsc_pkg::MAG_W-1:0]     mag_r [1:NST];
  logic                          neg_r [1:NST];
  logic signed [SW-1:0]          sa_r  [1:NST];
  logic signed [SW-1:0]          ca_r  [1:NST];
  logic [PW-1:0]                 pow_r [2:NST];

  logic [PL+tsc_pkg::MAG_W-1:0]  pplo_r;
  logic [PH+tsc_pkg::MAG_W-1:0]  pphi_r;
  logic [QW-1:0]                 q3_r, q4_r, q5_r;
  logic [2*QW-1:0]               qm4_r;
  logic [QW-1:0]                 qe5_r, qe6_r, rem6_r;

  logic [PROD_W-1:0]             prod_sum;
  logic [PW-1:0]                 pow2_nxt;
  logic [PW:0]                   qsum;
  logic [QW-1:0]                 q3_nxt;
  logic [2*QW-1:0]               qm4_nxt;
  logic [QW-1:0]                 rem6_nxt;
  logic [QW-1:0]                 term;
  logic                          term_neg;
  logic signed [SW-1:0]          term_s;
  logic signed [SW-1:0]          sa7_nxt, ca7_nxt;

  // stage 2: recombine partial products and round the next power
  assign prod_sum = (PROD_W'(pphi_r) << PL) + PROD_W'(pplo_r) + PROD_W'(RND_POW);
  assign pow2_nxt = prod_sum[tsc_pkg::ANGLE_FRAC +: PW];

  // stage 3: fold the rounding half and the 2^12 scale ahead of the factorial divide
  assign qsum   = {1'b0, pow_r[2]} + (PW+1)'(HALFD);
  assign q3_nxt = qsum[tsc_pkg::OUT_FRAC +: QW];

  // stage 4: reciprocal multiply, estimate is low by at most one
  assign qm4_nxt = (2*QW)'(q3_r) * (2*QW)'(RECIP);

  // stage 6: remainder of the estimate
  assign rem6_nxt = q5_r - qe5_r * QW'(FACT);

  // stage 7: correct the quotient, apply sign, accumulate
  assign term     = qe6_r + QW'(rem6_r >= QW'(FACT));
  assign term_neg = BASE_NEG ^ (neg_r[6] & ODD);
  assign term_s   = term_neg ? -$signed(SW'(term)) : $signed(SW'(term));
  assign sa7_nxt  = ODD ? (sa_r[6] + term_s) : sa_r[6];
  assign ca7_nxt  = ODD ? ca_r[6] : (ca_r[6] + term_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= NST; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[1] <= in_v;
      for (int i = 2; i <= NST; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r[1] <= in_mag;
      neg_r[1] <= in_neg;
      sa_r[1]  <= in_sa;
      ca_r[1]  <= in_ca;
      for (int i = 2; i <= NST; i++) begin
        mag_r[i] <= mag_r[i-1];
        neg_r[i] <= neg_r[i-1];
      end
      for (int i = 2; i < NST; i++) begin
        sa_r[i] <= sa_r[i-1];
        ca_r[i] <= ca_r[i-1];
      end
      sa_r[NST] <= sa7_nxt;
      ca_r[NST] <= ca7_nxt;

      pplo_r <= (PL+tsc_pkg::MAG_W)'(in_pow[PL-1:0]) * (PL+tsc_pkg::MAG_W)'(in_mag);
      pphi_r <= (PH+tsc_pkg::MAG_W)'(in_pow[PW-1:PL]) * (PH+tsc_pkg::MAG_W)'(in_mag);

      pow_r[2] <= pow2_nxt;
      for (int i = 3; i <= NST; i++) begin
        pow_r[i] <= pow_r[i-1];
      end

      q3_r   <= q3_nxt;
      q4_r   <= q3_r;
      qm4_r  <= qm4_nxt;
      q5_r   <= q4_r;
      qe5_r  <= qm4_r[QW +: QW];
      qe6_r  <= qe5_r;
      rem6_r <= rem6_nxt;
    end
  end

  assign out_v   = v_r[NST];
  assign out_mag = mag_r[NST];
  assign out_neg = neg_r[NST];
  assign out_pow = pow_r[NST];
  assign out_sa  = sa_r[NST];
  assign out_ca  = ca_r[NST];

endmodule

[rtl/core/tsc_out_buf.sv]
module tsc_out_buf (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  logic signed [tsc_pkg::OUT_W-1:0]  push_sin,
  input  logic signed [tsc_pkg::OUT_W-1:0]  push_cos,
  output logic                              room,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tsc_pkg::OUT_W-1:0]  out_sin,
  output logic signed [tsc_pkg::OUT_W-1:0]  out_cos
);

  localparam logic [1:0] FULL = 2'd2;

  logic signed [tsc_pkg::OUT_W-1:0] sin_r [2];
  logic signed [tsc_pkg::OUT_W-1:0] cos_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign cnt_nxt   = cnt_r + 2'(push) - 2'(pop);
  assign room      = cnt_r != FULL;
  assign out_valid = cnt_r != 2'd0;
  assign out_sin   = sin_r[rd_ptr_r];
  assign out_cos   = cos_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      sin_r[wr_ptr_r] <= push_sin;
      cos_r[wr_ptr_r] <= push_cos;
    end
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int AW = tsc_pkg::ANGLE_W;
  localparam int OW = tsc_pkg::OUT_W;
  localparam int N_SERIES = tsc_pkg::TERMS_DEF;
  localparam int N_DIR = 24;
  localparam int N_RANDOM = 1426;
  localparam int QUIET_FROM = 400;
  localparam int QUIET_TO = 700;
  localparam int HOLD_AT = 850;
  localparam int HOLD_CYCLES = 300;
  localparam int PAUSE_AT = 1150;
  localparam int TAIL_CYCLES = 14 * N_SERIES + 40;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic signed [AW-1:0] angle;
    logic signed [OW-1:0] sine;
    logic signed [OW-1:0] cosine;
  } trig_t;

  typedef struct packed {
    logic signed [AW-1:0] angle;
    bit                   typed;
    logic signed [OW-1:0] sine;
    logic signed [OW-1:0] cosine;
  } vec_t;

  // Only the trivially readable rows carry a typed result; the rest go through the predictor.
  localparam vec_t DIRECTED [0:N_DIR-1] = '{
    '{16'sd0,      1'b1, 16'sd0,  16'sd4096},
    '{16'sd1,      1'b1, 16'sd1,  16'sd4096},
    '{-16'sd1,     1'b1, -16'sd1, 16'sd4096},
    '{16'sd2,      1'b0, 16'sd0,  16'sd0},
    '{16'sd3,      1'b0, 16'sd0,  16'sd0},
    '{-16'sd3,     1'b0, 16'sd0,  16'sd0},
    '{16'sd32767,  1'b0, 16'sd0,  16'sd0},
    '{-16'sd32768, 1'b0, 16'sd0,  16'sd0},
    '{-16'sd32767, 1'b0, 16'sd0,  16'sd0},
    '{16'sd16384,  1'b0, 16'sd0,  16'sd0},
    '{-16'sd16384, 1'b0, 16'sd0,  16'sd0},
    '{16'sd16383,  1'b0, 16'sd0,  16'sd0},
    '{16'sd8192,   1'b0, 16'sd0,  16'sd0},
    '{-16'sd8192,  1'b0, 16'sd0,  16'sd0},
    '{16'sd25736,  1'b0, 16'sd0,  16'sd0},
    '{-16'sd25736, 1'b0, 16'sd0,  16'sd0},
    '{16'sd12868,  1'b0, 16'sd0,  16'sd0},
    '{-16'sd12868, 1'b0, 16'sd0,  16'sd0},
    '{16'sd21845,  1'b0, 16'sd0,  16'sd0},
    '{-16'sd21846, 1'b0, 16'sd0,  16'sd0},
    '{16'sd24576,  1'b0, 16'sd0,  16'sd0},
    '{-16'sd24576, 1'b0, 16'sd0,  16'sd0},
    '{16'sd4096,   1'b0, 16'sd0,  16'sd0},
    '{-16'sd4096,  1'b0, 16'sd0,  16'sd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [AW-1:0] in_angle = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic signed [OW-1:0] out_sine_value;
  logic signed [OW-1:0] out_cosine_value;

  trig_t trig_due[$];
  int n_sent = 0;
  int n_checked = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  int held_cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  taylor_sine_cosine_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_angle         (in_angle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sine_value   (out_sine_value),
    .out_cosine_value (out_cosine_value)
  );

  always #5 clk = ~clk;

  // Add the alternating terms |x|^n / n!, n = first_exp, first_exp + 2, ...
  function automatic longint signed add_series(input longint unsigned mag, input bit neg,
                                               input int first_exp, input longint signed acc);
    longint unsigned pw;
    longint unsigned nfact;
    longint unsigned den;
    longint unsigned term;
    int e;
    int n;
    bit sub;
    pw = mag << (tsc_pkg::POW_FRAC - tsc_pkg::ANGLE_FRAC);
    e = 1;
    for (int k = 0; k < N_SERIES; k++) begin
      n = first_exp + 2 * k;
      while (e < n) begin
        pw = (pw * mag + (64'd1 << (tsc_pkg::ANGLE_FRAC - 1))) >> tsc_pkg::ANGLE_FRAC;
        e++;
      end
      nfact = 1;
      for (int i = 2; i <= n; i++) nfact = nfact * longint'(i);
      den = nfact << (tsc_pkg::POW_FRAC - tsc_pkg::OUT_FRAC);
      term = (pw + den / 2) / den;
      // first term after the leading one subtracts; odd powers of a negative angle flip
      sub = ((k % 2) == 0) != (neg && n[0]);
      acc = sub ? acc - longint'(term) : acc + longint'(term);
    end
    return acc;
  endfunction

  function automatic logic signed [OW-1:0] clip_q412(input longint signed v);
    if (v > tsc_pkg::OUT_MAX) return OW'(tsc_pkg::OUT_MAX);
    if (v < tsc_pkg::OUT_MIN) return OW'(tsc_pkg::OUT_MIN);
    return OW'(v);
  endfunction

  function automatic trig_t taylor_trig(input logic signed [AW-1:0] ang);
    trig_t r;
    bit neg;
    longint unsigned mag;
    longint unsigned lead;
    longint signed s_acc;
    longint signed c_acc;
    neg = ang[AW-1];
    mag = neg ? (64'h10000 - longint'(unsigned'(ang))) : longint'(unsigned'(ang));
    lead = (mag + 1) >> 1;
    s_acc = neg ? -longint'(lead) : longint'(lead);
    c_acc = tsc_pkg::COS_ONE;
    r.angle = ang;
    r.sine = clip_q412(add_series(mag, neg, 3, s_acc));
    r.cosine = clip_q412(add_series(mag, neg, 2, c_acc));
    return r;
  endfunction

  task automatic offer_angle(input logic signed [AW-1:0] ang, input bit typed,
                             input trig_t typed_res);
    while (!quiet && !hold_req && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= ang;
    do @(posedge clk); while (!in_ready);
    trig_due.push_back(typed ? typed_res : taylor_trig(ang));
    n_sent++;
  endtask

  initial begin
    int mode;
    logic signed [AW-1:0] ang;
    trig_t typed_res;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      typed_res.angle = DIRECTED[i].angle;
      typed_res.sine = DIRECTED[i].sine;
      typed_res.cosine = DIRECTED[i].cosine;
      offer_angle(DIRECTED[i].angle, DIRECTED[i].typed, typed_res);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        ang = AW'($urandom);
      end else if (mode < 8) begin
        ang = AW'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1) ang = -ang;
      end else if ($urandom_range(0, 1) == 1) begin
        ang = 16'sh7FFF - AW'($urandom_range(0, 63));
      end else begin
        ang = 16'sh8000 + AW'($urandom_range(0, 63));
      end
      quiet = (i >= QUIET_FROM && i < QUIET_TO);
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == PAUSE_AT) begin
        // drain the pipe completely before going on
        in_valid <= 1'b0;
        do @(posedge clk); while (trig_due.size() != 0);
      end
      offer_angle(ang, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (trig_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("tb: %0d angles sent (%0d directed incl. -4.0 and rounding ties, %0d random)",
             n_sent, N_DIR, N_RANDOM);
    $display("tb: %0d results checked, output held off %0d cycles, one full drain, %0d mismatches",
             n_checked, held_cycles, mismatches);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Result side: random backpressure, one long hold-off on request.
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          held_cycles++;
        end
        hold_req = 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  always @(posedge clk) begin
    trig_t e;
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (trig_due.size() == 0) begin
        if (mismatches < 10)
          $display("tb: unexpected transaction sine %0d cosine %0d",
                   out_sine_value, out_cosine_value);
        mismatches++;
      end else begin
        e = trig_due.pop_front();
        if (out_sine_value !== e.sine || out_cosine_value !== e.cosine) begin
          if (mismatches < 10)
            $display("tb: angle %0d: sine exp %0d got %0d, cosine exp %0d got %0d",
                     e.angle, e.sine, out_sine_value, e.cosine, out_cosine_value);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: give up when neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: no transaction for %0d cycles, %0d results outstanding",
                 stall_cycles, trig_due.size());
        $display("tb: done, errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule
